### hdl/utf8v_pkg.sv
// shared types and constants for the utf-8 validator with first-error report
// no dependencies
`timescale 1ns / 1ps

package utf8v_pkg;

  localparam int DEFAULT_OFFSET_BITS = 32;
  localparam int ERR_OFFSET_W        = 32;

  // byte classification masks and patterns
  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] MASK_2B      = 8'hE0;
  localparam logic [7:0] LEAD_2B      = 8'hC0;
  localparam logic [7:0] MASK_3B      = 8'hF0;
  localparam logic [7:0] LEAD_3B      = 8'hE0;
  localparam logic [7:0] MASK_4B      = 8'hF8;
  localparam logic [7:0] LEAD_4B      = 8'hF0;
  localparam logic [7:0] MASK_CONT    = 8'hC0;
  localparam logic [7:0] CONT_PAT     = 8'h80;
  localparam logic [7:0] CONT_MAX     = 8'hBF;
  localparam logic [5:0] PAYLOAD_MASK = 6'h3F;

  // code point limits
  localparam logic [20:0] MIN_CP_2B     = 21'h00080;
  localparam logic [20:0] MIN_CP_3B     = 21'h00800;
  localparam logic [20:0] MIN_CP_4B     = 21'h10000;
  localparam logic [20:0] SURR_LO       = 21'h0D800;
  localparam logic [20:0] SURR_HI       = 21'h0DFFF;
  localparam logic [20:0] MAX_CP        = 21'h10FFFF;

  localparam logic [2:0] SEQ_LEN_2 = 3'd2;
  localparam logic [2:0] SEQ_LEN_3 = 3'd3;
  localparam logic [2:0] SEQ_LEN_4 = 3'd4;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_HELD = 2'd1,
    ERR_DONE = 2'd2
  } err_state_t;

  typedef enum logic [3:0] {
    KIND_NONE       = 4'd0,
    KIND_STRAY_CONT = 4'd1,
    KIND_BAD_LEAD   = 4'd2,
    KIND_INCOMPLETE = 4'd3,
    KIND_EXP_CONT   = 4'd4,
    KIND_OVERLONG2  = 4'd5,
    KIND_OVERLONG3  = 4'd6,
    KIND_OVERLONG4  = 4'd7,
    KIND_SURROGATE  = 4'd8,
    KIND_ABOVE_MAX  = 4'd9
  } err_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                    valid_res;
    logic [3:0]              error_kind;
    logic [ERR_OFFSET_W-1:0] fault_offset;
    logic [7:0]              fault_byte;
  } out_item_t;

endpackage

### hdl/utf8v_core.sv
// per-byte decode state and first-error tracking for one string
// depends on utf8v_pkg
`timescale 1ns / 1ps

module utf8v_core #(
  parameter int OFFSET_BITS = utf8v_pkg::DEFAULT_OFFSET_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  utf8v_pkg::in_item_t  item,
  output utf8v_pkg::out_item_t result
);

  import utf8v_pkg::*;

  logic [1:0]             bytes_left_r, bytes_left_nxt;
  logic [2:0]             seq_len_r, seq_len_nxt;
  logic [20:0]            cp_r, cp_nxt;
  logic [7:0]             lead_val_r, lead_val_nxt;
  logic [OFFSET_BITS-1:0] lead_pos_r, lead_pos_nxt;
  logic [OFFSET_BITS-1:0] cnt_r, cnt_nxt;
  err_state_t             err_st_r, err_st_nxt;
  err_kind_t              held_kind_r, held_kind_nxt;
  logic [OFFSET_BITS-1:0] held_pos_r, held_pos_nxt;
  logic [7:0]             held_val_r, held_val_nxt;

  // values after this beat, before the end-of-string clear
  err_state_t             es_w;
  err_kind_t              kind_w;
  logic [OFFSET_BITS-1:0] pos_w;
  logic [7:0]             val_w;
  logic [OFFSET_BITS+ERR_OFFSET_W-1:0] pos_ext;

  always_comb begin
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] pos;
    logic [1:0]             bl;
    logic [2:0]             sl;
    logic [20:0]            cp;
    logic [7:0]             lv;
    logic [OFFSET_BITS-1:0] lp;
    err_kind_t              fk;
    b  = item.data_byte;
    pos = cnt_r;
    bl = bytes_left_r;
    sl = seq_len_r;
    cp = cp_r;
    lv = lead_val_r;
    lp = lead_pos_r;
    fk = KIND_NONE;
    es_w   = err_st_r;
    kind_w = held_kind_r;
    pos_w  = held_pos_r;
    val_w  = held_val_r;

    if (err_st_r == ERR_DONE) begin
      // only counting
    end else if (bytes_left_r == 2'd0) begin
      if (b < ASCII_LIMIT) begin
        // ascii
      end else if ((b & MASK_2B) == LEAD_2B) begin
        sl = SEQ_LEN_2;
        bl = 2'd1;
        cp = {16'd0, b[4:0]};
      end else if ((b & MASK_3B) == LEAD_3B) begin
        sl = SEQ_LEN_3;
        bl = 2'd2;
        cp = {17'd0, b[3:0]};
      end else if ((b & MASK_4B) == LEAD_4B) begin
        sl = SEQ_LEN_4;
        bl = 2'd3;
        cp = {18'd0, b[2:0]};
      end else begin
        es_w   = ERR_DONE;
        kind_w = (b <= CONT_MAX) ? KIND_STRAY_CONT : KIND_BAD_LEAD;
        pos_w  = pos;
        val_w  = b;
      end
      if (bl != 2'd0) begin
        lv = b;
        lp = pos;
      end
    end else begin
      if (err_st_r == ERR_NONE) begin
        if ((b & MASK_CONT) != CONT_PAT) begin
          es_w   = ERR_HELD;
          kind_w = KIND_EXP_CONT;
          pos_w  = pos;
          val_w  = b;
        end else begin
          cp = {cp_r[14:0], b[5:0] & PAYLOAD_MASK};
        end
      end
      bl = bytes_left_r - 2'd1;
      if (bl == 2'd0) begin
        if (es_w == ERR_HELD) begin
          es_w = ERR_DONE;
        end else begin
          if (sl == SEQ_LEN_2 && cp < MIN_CP_2B) fk = KIND_OVERLONG2;
          else if (sl == SEQ_LEN_3 && cp < MIN_CP_3B) fk = KIND_OVERLONG3;
          else if (sl == SEQ_LEN_4 && cp < MIN_CP_4B) fk = KIND_OVERLONG4;
          else if (cp >= SURR_LO && cp <= SURR_HI) fk = KIND_SURROGATE;
          else if (cp > MAX_CP) fk = KIND_ABOVE_MAX;
          if (fk != KIND_NONE) begin
            es_w   = ERR_DONE;
            kind_w = fk;
            pos_w  = lp;
            val_w  = lv;
          end
        end
      end
    end

    // string ends inside a sequence
    if (item.last_byte && es_w != ERR_DONE && bl != 2'd0) begin
      es_w   = ERR_DONE;
      kind_w = KIND_INCOMPLETE;
      pos_w  = lp;
      val_w  = lv;
    end

    if (item.last_byte) begin
      bytes_left_nxt = '0;
      seq_len_nxt    = '0;
      cp_nxt         = '0;
      lead_val_nxt   = '0;
      lead_pos_nxt   = '0;
      cnt_nxt        = '0;
      err_st_nxt     = ERR_NONE;
      held_kind_nxt  = KIND_NONE;
      held_pos_nxt   = '0;
      held_val_nxt   = '0;
    end else begin
      bytes_left_nxt = bl;
      seq_len_nxt    = sl;
      cp_nxt         = cp;
      lead_val_nxt   = lv;
      lead_pos_nxt   = lp;
      cnt_nxt        = (cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;
      err_st_nxt     = es_w;
      held_kind_nxt  = kind_w;
      held_pos_nxt   = pos_w;
      held_val_nxt   = val_w;
    end
  end

  assign pos_ext = {{ERR_OFFSET_W{1'b0}}, pos_w};

  always_comb begin
    if (es_w == ERR_DONE) begin
      result.valid_res    = 1'b0;
      result.error_kind   = kind_w;
      result.fault_offset = pos_ext[ERR_OFFSET_W-1:0];
      result.fault_byte   = val_w;
    end else begin
      result.valid_res    = 1'b1;
      result.error_kind   = KIND_NONE;
      result.fault_offset = '0;
      result.fault_byte   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      seq_len_r    <= '0;
      cp_r         <= '0;
      lead_val_r   <= '0;
      lead_pos_r   <= '0;
      cnt_r        <= '0;
      err_st_r     <= ERR_NONE;
      held_kind_r  <= KIND_NONE;
      held_pos_r   <= '0;
      held_val_r   <= '0;
    end else if (step_en) begin
      bytes_left_r <= bytes_left_nxt;
      seq_len_r    <= seq_len_nxt;
      cp_r         <= cp_nxt;
      lead_val_r   <= lead_val_nxt;
      lead_pos_r   <= lead_pos_nxt;
      cnt_r        <= cnt_nxt;
      err_st_r     <= err_st_nxt;
      held_kind_r  <= held_kind_nxt;
      held_pos_r   <= held_pos_nxt;
      held_val_r   <= held_val_nxt;
    end
  end

endmodule

### hdl/utf8_validator_with_error_report_top.sv
// top level of the utf-8 validator: input beat register, decode core, result register
// depends on utf8v_pkg and utf8v_core
`timescale 1ns / 1ps

// Checks a byte string for valid UTF-8, one byte per beat, last_byte set on the
// final byte. One result beat follows each string: valid_res, or the first error's
// kind, offset and byte (lead's for sequence errors but a missing continuation).
// Throughput is one byte per clock, set by the single decode state update per byte;
// a result is registered as its last byte steps the core. With a result waiting,
// the input register keeps taking bytes until the next last byte arrives, then
// stalls. Offsets saturate at 2**OFFSET_BITS - 1, reported in their low 32 bits.
module utf8_validator_with_error_report_top #(
  parameter int OFFSET_BITS = utf8v_pkg::DEFAULT_OFFSET_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utf8v_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf8v_pkg::out_item_t out_data
);

  import utf8v_pkg::*;

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t core_res;
  logic      go;
  logic      step;

  assign go       = !in_data_r.last_byte || !out_valid_r || out_ready;
  assign step     = in_valid_r && go;
  assign in_ready = !in_valid_r || go;

  always_comb begin
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_comb begin
    if (step && in_data_r.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  utf8v_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step),
    .item   (in_data_r),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (step && in_data_r.last_byte) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_valid_res_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res |->
      out_data.error_kind == KIND_NONE && out_data.fault_offset == '0 &&
      out_data.fault_byte == '0)
    else $error("valid result carries error fields");

  a_error_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |->
      out_data.error_kind != KIND_NONE && out_data.error_kind <= KIND_ABOVE_MAX)
    else $error("error result with bad kind");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(step && in_data_r.last_byte))
    else $error("result without a last byte");

  a_no_drop_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !(step && in_data_r.last_byte))
    else $error("pending result overwritten");
`endif

endmodule
